[sv/cau_pkg.sv]
// Shared operation codes, status codes and field widths of the complex arithmetic unit.
package cau_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TOL_W    = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_EQ  = 3'd4,
        FUNC_NE  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

endpackage

[sv/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: front stages, divider cell chain, output stage.
//
// Usage: a request carries func and the two complex operands a and b in signed
// fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits). It is taken on the
// input channel when in_valid and in_ready are both high at a clock edge.
// One result per request leaves on the output channel (out_valid/out_ready)
// in request order: res_re, res_im, compare_true and status.
// Every operation passes through the same registers: three front stages
// (products, sums, divider seed), one division cell per quotient bit, and the
// output register. Throughput is one request per cycle while the receiver
// takes results; each stage moves on whenever the stage after it is empty or
// moving, so bubbles close up. When the receiver stalls, results pile up stage
// by stage and in_ready drops only once the whole chain is full. The user writes
// eq_tolerance through cfg_we/cfg_wdata only while the unit is idle; the unit
// does not enforce this. Reset clears all valid bits and the tolerance; data
// registers are not reset.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cau_pkg::FUNC_W-1:0]    func,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic                          compare_true,
    output logic [cau_pkg::STATUS_W-1:0]  status,
    input  logic                          cfg_we,
    input  logic [cau_pkg::TOL_W-1:0]     cfg_wdata
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * W + 1;
    localparam int SW = 2 * W + 9;

    // Tolerance register for the equal and not-equal tests.
    logic [TOL_W-1:0] eq_tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_tolerance_reg <= '0;
        end
        else if (cfg_we)
        begin
            eq_tolerance_reg <= cfg_wdata;
        end
    end

    // Links of the divider chain; link 0 is fed by the front stages.
    logic           c_valid [0:W];
    logic           c_ready [0:W];
    logic [RW-1:0]  c_rem_re [0:W];
    logic [RW-1:0]  c_rem_im [0:W];
    logic [W-1:0]   c_nlo_re [0:W];
    logic [W-1:0]   c_nlo_im [0:W];
    logic [W-1:0]   c_q_re [0:W];
    logic [W-1:0]   c_q_im [0:W];
    logic [2*W-1:0] c_den [0:W];
    logic [SW-1:0]  c_side [0:W];

    cau_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .tol       (eq_tolerance_reg),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .rem_re    (c_rem_re[0]),
        .rem_im    (c_rem_im[0]),
        .nlo_re    (c_nlo_re[0]),
        .nlo_im    (c_nlo_im[0]),
        .den       (c_den[0]),
        .side      (c_side[0])
    );

    // The quotient starts empty and gains one bit per cell, most significant first.
    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_cell
        cau_div_cell #(
            .W (W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (c_valid[k]),
            .in_ready   (c_ready[k]),
            .in_rem_re  (c_rem_re[k]),
            .in_rem_im  (c_rem_im[k]),
            .in_nlo_re  (c_nlo_re[k]),
            .in_nlo_im  (c_nlo_im[k]),
            .in_q_re    (c_q_re[k]),
            .in_q_im    (c_q_im[k]),
            .in_den     (c_den[k]),
            .in_side    (c_side[k]),
            .out_valid  (c_valid[k+1]),
            .out_ready  (c_ready[k+1]),
            .out_rem_re (c_rem_re[k+1]),
            .out_rem_im (c_rem_im[k+1]),
            .out_nlo_re (c_nlo_re[k+1]),
            .out_nlo_im (c_nlo_im[k+1]),
            .out_q_re   (c_q_re[k+1]),
            .out_q_im   (c_q_im[k+1]),
            .out_den    (c_den[k+1]),
            .out_side   (c_side[k+1])
        );
    end

    cau_back #(
        .W (W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (c_valid[W]),
        .in_ready     (c_ready[W]),
        .q_re         (c_q_re[W]),
        .q_im         (c_q_im[W]),
        .side         (c_side[W]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res_re       (res_re),
        .res_im       (res_im),
        .compare_true (compare_true),
        .status       (status)
    );

    // A division by zero always returns a zero result.
    a_div_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIV_ZERO |-> res_re == '0 && res_im == '0)
        else $error("division by zero with nonzero result");

    // A true comparison carries no arithmetic result and no error.
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> res_re == '0 && res_im == '0 && status == ST_OK)
        else $error("comparison result mixed with arithmetic result");

    // Only defined status codes leave the unit.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_DIV_ZERO || status == ST_SAT)
        else $error("undefined status code");

    // The input stalls only when the output is held up.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output is free");

endmodule

[sv/cau_front.sv]
// Front pipeline: products, sums, compare, saturation and divider setup.
module cau_front #(
    parameter int W = 32,
    parameter int F = 16,
    localparam int RW = 2 * W + 1,
    localparam int SW = 2 * W + 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [cau_pkg::FUNC_W-1:0] func,
    input  logic signed [W-1:0]       a_re,
    input  logic signed [W-1:0]       a_im,
    input  logic signed [W-1:0]       b_re,
    input  logic signed [W-1:0]       b_im,
    input  logic [cau_pkg::TOL_W-1:0] tol,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [RW-1:0]             rem_re,
    output logic [RW-1:0]             rem_im,
    output logic [W-1:0]              nlo_re,
    output logic [W-1:0]              nlo_im,
    output logic [2*W-1:0]            den,
    output logic [SW-1:0]             side
);
    import cau_pkg::*;

    localparam int XW = 3 * W + F + 1;
    localparam int TW = cau_pkg::TOL_W;
    localparam logic signed [2*W:0] MAXV = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W:0] MINV = {{(W+2){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_fn(input logic signed [2*W:0] v);
        logic hi;
        logic lo;
        hi = v > MAXV;
        lo = v < MINV;
        if (hi)
        begin
            return {1'b1, MAXV[W-1:0]};
        end
        else if (lo)
        begin
            return {1'b1, MINV[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    // ---------------- stage A: products, add/sub, compare ----------------
    func_t f_in;
    logic ready_a, ready_b, ready_c;
    logic signed [W:0] sre_next, sim_next, dre, dim;
    logic [W:0] adre, adim;
    logic eq_hit, cmp_next;
    logic signed [2*W-1:0] ac_next, bd_next, ad_next, bc_next, cc_next, dd_next;

    logic va_reg;
    func_t func_a_reg;
    logic signed [2*W-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [W:0] sre_reg, sim_reg;
    logic cmp_a_reg;

    assign f_in = func_t'(func);
    assign ac_next = a_re * b_re;
    assign bd_next = a_im * b_im;
    assign ad_next = a_re * b_im;
    assign bc_next = a_im * b_re;
    assign cc_next = b_re * b_re;
    assign dd_next = b_im * b_im;

    assign dre = {a_re[W-1], a_re} - {b_re[W-1], b_re};
    assign dim = {a_im[W-1], a_im} - {b_im[W-1], b_im};
    assign adre = dre[W] ? $unsigned(-dre) : $unsigned(dre);
    assign adim = dim[W] ? $unsigned(-dim) : $unsigned(dim);
    assign eq_hit = ({{TW{1'b0}}, adre} <= {{(W+1){1'b0}}, tol})
                 && ({{TW{1'b0}}, adim} <= {{(W+1){1'b0}}, tol});
    assign cmp_next = (f_in == FUNC_EQ) ? eq_hit : ((f_in == FUNC_NE) ? !eq_hit : 1'b0);

    always_comb
    begin
        if (f_in == FUNC_SUB)
        begin
            sre_next = dre;
            sim_next = dim;
        end
        else
        begin
            sre_next = {a_re[W-1], a_re} + {b_re[W-1], b_re};
            sim_next = {a_im[W-1], a_im} + {b_im[W-1], b_im};
        end
    end

    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            func_a_reg <= f_in;
            ac_reg     <= ac_next;
            bd_reg     <= bd_next;
            ad_reg     <= ad_next;
            bc_reg     <= bc_next;
            cc_reg     <= cc_next;
            dd_reg     <= dd_next;
            sre_reg    <= sre_next;
            sim_reg    <= sim_next;
            cmp_a_reg  <= cmp_next;
        end
    end

    // ---------------- stage B: sums, saturation, magnitudes ----------------
    logic signed [2*W:0] mul_re, mul_im, nr, ni, sh_re, sh_im;
    logic [2*W:0] den_sum;
    logic [2*W:0] mag_re, mag_im;
    logic [W:0] sat_re, sat_im;
    logic [W-1:0] res_re_next, res_im_next;
    logic [1:0] st_next;
    logic isdiv_next;

    logic vb_reg;
    logic [W-1:0] res_re_b_reg, res_im_b_reg;
    logic cmp_b_reg;
    logic [1:0] st_b_reg;
    logic isdiv_b_reg, dz_b_reg, nre_b_reg, nim_b_reg;
    logic [2*W-1:0] mre_b_reg, mim_b_reg, den_b_reg;

    assign mul_re  = {ac_reg[2*W-1], ac_reg} - {bd_reg[2*W-1], bd_reg};
    assign mul_im  = {ad_reg[2*W-1], ad_reg} + {bc_reg[2*W-1], bc_reg};
    assign nr      = {ac_reg[2*W-1], ac_reg} + {bd_reg[2*W-1], bd_reg};
    assign ni      = {bc_reg[2*W-1], bc_reg} - {ad_reg[2*W-1], ad_reg};
    assign den_sum = {1'b0, cc_reg} + {1'b0, dd_reg};

    // Numerator magnitudes never exceed 2^(2W-1), so the low 2W bits hold them.
    assign mag_re  = nr[2*W] ? $unsigned(-nr) : $unsigned(nr);
    assign mag_im  = ni[2*W] ? $unsigned(-ni) : $unsigned(ni);

    always_comb
    begin
        sh_re       = {{W{sre_reg[W]}}, sre_reg};
        sh_im       = {{W{sim_reg[W]}}, sim_reg};
        res_re_next = '0;
        res_im_next = '0;
        st_next     = ST_OK;
        isdiv_next  = 1'b0;
        if (func_a_reg == FUNC_MUL)
        begin
            sh_re = mul_re >>> F;
            sh_im = mul_im >>> F;
        end
        sat_re = sat_fn(sh_re);
        sat_im = sat_fn(sh_im);
        case (func_a_reg)
            FUNC_ADD, FUNC_SUB, FUNC_MUL:
            begin
                res_re_next = sat_re[W-1:0];
                res_im_next = sat_im[W-1:0];
                st_next     = (sat_re[W] || sat_im[W]) ? ST_SAT : ST_OK;
            end
            FUNC_DIV:
            begin
                isdiv_next = 1'b1;
            end
            default:
            begin
                isdiv_next = 1'b0;
            end
        endcase
    end

    assign ready_b = !vb_reg || ready_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg)
        begin
            res_re_b_reg <= res_re_next;
            res_im_b_reg <= res_im_next;
            cmp_b_reg    <= cmp_a_reg;
            st_b_reg     <= st_next;
            isdiv_b_reg  <= isdiv_next;
            dz_b_reg     <= (den_sum[2*W-1:0] == '0);
            nre_b_reg    <= nr[2*W];
            nim_b_reg    <= ni[2*W];
            mre_b_reg    <= mag_re[2*W-1:0];
            mim_b_reg    <= mag_im[2*W-1:0];
            den_b_reg    <= den_sum[2*W-1:0];
        end
    end

    // ---------------- stage C: quotient range check, remainder seed ----------------
    logic [XW-1:0] xre, xim, dx;
    logic ovf_re, ovf_im;

    logic vc_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg;
    logic [W-1:0] nlo_re_reg, nlo_im_reg;
    logic [2*W-1:0] den_c_reg;
    logic [SW-1:0] side_reg;

    // The quotient reaches 2^W exactly when the scaled numerator reaches den * 2^W.
    assign xre    = {{(W+1){1'b0}}, mre_b_reg, {F{1'b0}}};
    assign xim    = {{(W+1){1'b0}}, mim_b_reg, {F{1'b0}}};
    assign dx     = {{(F+1){1'b0}}, den_b_reg, {W{1'b0}}};
    assign ovf_re = xre >= dx;
    assign ovf_im = xim >= dx;

    assign ready_c = !vc_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (ready_c)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && vb_reg)
        begin
            rem_re_reg <= xre[W +: RW];
            rem_im_reg <= xim[W +: RW];
            nlo_re_reg <= xre[W-1:0];
            nlo_im_reg <= xim[W-1:0];
            den_c_reg  <= den_b_reg;
            side_reg   <= {res_re_b_reg, res_im_b_reg, cmp_b_reg, st_b_reg, isdiv_b_reg,
                           dz_b_reg, nre_b_reg, nim_b_reg, ovf_re, ovf_im};
        end
    end

    assign out_valid = vc_reg;
    assign rem_re    = rem_re_reg;
    assign rem_im    = rem_im_reg;
    assign nlo_re    = nlo_re_reg;
    assign nlo_im    = nlo_im_reg;
    assign den       = den_c_reg;
    assign side      = side_reg;

endmodule

[sv/cau_div_cell.sv]
// One restoring-division cell: one quotient bit for each of the two parts.
module cau_div_cell #(
    parameter int W = 32,
    localparam int RW = 2 * W + 1,
    localparam int SW = 2 * W + 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [RW-1:0]   in_rem_re,
    input  logic [RW-1:0]   in_rem_im,
    input  logic [W-1:0]    in_nlo_re,
    input  logic [W-1:0]    in_nlo_im,
    input  logic [W-1:0]    in_q_re,
    input  logic [W-1:0]    in_q_im,
    input  logic [2*W-1:0]  in_den,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [RW-1:0]   out_rem_re,
    output logic [RW-1:0]   out_rem_im,
    output logic [W-1:0]    out_nlo_re,
    output logic [W-1:0]    out_nlo_im,
    output logic [W-1:0]    out_q_re,
    output logic [W-1:0]    out_q_im,
    output logic [2*W-1:0]  out_den,
    output logic [SW-1:0]   out_side
);
    logic [RW-1:0] t_re, t_im, dext;
    logic ge_re, ge_im;

    logic v_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg;
    logic [W-1:0] nlo_re_reg, nlo_im_reg, q_re_reg, q_im_reg;
    logic [2*W-1:0] den_reg;
    logic [SW-1:0] side_reg;

    // With no quotient overflow the remainder is below the divisor: top bit clear.
    assign dext  = {1'b0, in_den};
    assign t_re  = {in_rem_re[RW-2:0], in_nlo_re[W-1]};
    assign t_im  = {in_rem_im[RW-2:0], in_nlo_im[W-1]};
    assign ge_re = t_re >= dext;
    assign ge_im = t_im >= dext;

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_re_reg <= ge_re ? t_re - dext : t_re;
            rem_im_reg <= ge_im ? t_im - dext : t_im;
            nlo_re_reg <= {in_nlo_re[W-2:0], 1'b0};
            nlo_im_reg <= {in_nlo_im[W-2:0], 1'b0};
            q_re_reg   <= {in_q_re[W-2:0], ge_re};
            q_im_reg   <= {in_q_im[W-2:0], ge_im};
            den_reg    <= in_den;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = v_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_nlo_re = nlo_re_reg;
    assign out_nlo_im = nlo_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_den    = den_reg;
    assign out_side   = side_reg;

endmodule

[sv/cau_back.sv]
// Output stage: quotient sign and saturation, result selection, output register.
module cau_back #(
    parameter int W = 32,
    localparam int SW = 2 * W + 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [W-1:0]                 q_re,
    input  logic [W-1:0]                 q_im,
    input  logic [SW-1:0]                side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [W-1:0]                 res_re,
    output logic [W-1:0]                 res_im,
    output logic                         compare_true,
    output logic [cau_pkg::STATUS_W-1:0] status
);
    import cau_pkg::*;

    localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};

    function automatic logic [W:0] fix_fn(input logic [W-1:0] q, input logic neg,
                                          input logic ovf);
        logic [W:0] lim;
        logic [W:0] hmin;
        lim  = neg ? HALF : HALF - 1'b1;
        hmin = HALF - 1'b1;
        if (ovf || ({1'b0, q} > lim))
        begin
            return {1'b1, neg ? HALF[W-1:0] : hmin[W-1:0]};
        end
        return {1'b0, neg ? W'(-q) : q};
    endfunction

    logic [W-1:0] s_res_re, s_res_im;
    logic s_cmp, s_isdiv, s_dz, s_nre, s_nim, s_ovre, s_ovim;
    logic [1:0] s_st;
    logic [W:0] fre, fim;
    logic [W-1:0] res_re_next, res_im_next;
    status_t st_next;

    logic v_reg;
    logic [W-1:0] res_re_reg, res_im_reg;
    logic cmp_reg;
    status_t st_reg;

    assign {s_res_re, s_res_im, s_cmp, s_st, s_isdiv, s_dz, s_nre, s_nim, s_ovre, s_ovim} = side;
    assign fre = fix_fn(q_re, s_nre, s_ovre);
    assign fim = fix_fn(q_im, s_nim, s_ovim);

    always_comb
    begin
        res_re_next = s_res_re;
        res_im_next = s_res_im;
        st_next     = status_t'(s_st);
        if (s_isdiv)
        begin
            if (s_dz)
            begin
                res_re_next = '0;
                res_im_next = '0;
                st_next     = ST_DIV_ZERO;
            end
            else
            begin
                res_re_next = fre[W-1:0];
                res_im_next = fim[W-1:0];
                st_next     = (fre[W] || fim[W]) ? ST_SAT : ST_OK;
            end
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            cmp_reg    <= s_cmp;
            st_reg     <= st_next;
        end
    end

    assign out_valid    = v_reg;
    assign res_re       = res_re_reg;
    assign res_im       = res_im_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule
